@@ rtl/core/smeu_pkg.sv @@
`default_nettype none
package smeu_pkg;

  localparam logic [4:0] OP_PUSH   = 5'd0;
  localparam logic [4:0] OP_DUP    = 5'd1;
  localparam logic [4:0] OP_DROP   = 5'd2;
  localparam logic [4:0] OP_SWAP   = 5'd3;
  localparam logic [4:0] OP_OVER   = 5'd4;
  localparam logic [4:0] OP_ROT    = 5'd5;
  localparam logic [4:0] OP_DOT    = 5'd6;
  localparam logic [4:0] OP_EMIT   = 5'd7;
  localparam logic [4:0] OP_CR     = 5'd8;
  localparam logic [4:0] OP_EQ     = 5'd9;
  localparam logic [4:0] OP_LT     = 5'd10;
  localparam logic [4:0] OP_GT     = 5'd11;
  localparam logic [4:0] OP_INVERT = 5'd12;
  localparam logic [4:0] OP_AND    = 5'd13;
  localparam logic [4:0] OP_OR     = 5'd14;
  localparam logic [4:0] OP_ADD    = 5'd15;
  localparam logic [4:0] OP_SUB    = 5'd16;
  localparam logic [4:0] OP_MUL    = 5'd17;
  localparam logic [4:0] OP_DIV    = 5'd18;
  localparam logic [4:0] OP_FETCH  = 5'd19;
  localparam logic [4:0] OP_STORE  = 5'd20;

  localparam logic [2:0] ERR_NONE  = 3'd0;
  localparam logic [2:0] ERR_UNDER = 3'd1;
  localparam logic [2:0] ERR_OVER  = 3'd2;
  localparam logic [2:0] ERR_DIVZ  = 3'd3;
  localparam logic [2:0] ERR_ADDR  = 3'd4;

  localparam logic [1:0] PK_NONE = 2'd0;
  localparam logic [1:0] PK_NUM  = 2'd1;
  localparam logic [1:0] PK_CHAR = 2'd2;
  localparam logic [1:0] PK_NL   = 2'd3;

  localparam logic [31:0] TRUE_WORD = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [4:0]         mode;
    logic signed [31:0] literal;
  } in_t;

  typedef struct packed {
    logic [1:0]         print_kind;
    logic signed [31:0] print_value;
    logic [2:0]         error_code;
    logic [7:0]         depth_after;
    logic signed [31:0] top_after;
  } out_t;

  // Number of operands each operation needs on the stack.
  function automatic logic [1:0] need_f(input logic [4:0] mode);
    logic [1:0] n;
    case (mode)
      OP_PUSH, OP_CR:                          n = 2'd0;
      OP_DUP, OP_DROP, OP_DOT, OP_EMIT,
      OP_INVERT, OP_FETCH:                     n = 2'd1;
      OP_ROT:                                  n = 2'd3;
      default:                                 n = 2'd2;
    endcase
    return n;
  endfunction

  function automatic logic [31:0] flag_f(input logic c);
    return c ? TRUE_WORD : 32'd0;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/smeu_alu.sv @@
`default_nettype none
module smeu_alu
  import smeu_pkg::*;
(
  input  wire logic [4:0]  mode,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic [31:0]      r
);

  logic [31:0] prod;

  assign prod = b * a;

  always_comb begin
    case (mode)
      OP_EQ:     r = flag_f(a == b);
      OP_LT:     r = flag_f($signed(b) < $signed(a));
      OP_GT:     r = flag_f($signed(b) > $signed(a));
      OP_INVERT: r = ~a;
      OP_AND:    r = flag_f(a == TRUE_WORD && b == TRUE_WORD);
      OP_OR:     r = flag_f(a == TRUE_WORD || b == TRUE_WORD);
      OP_ADD:    r = b + a;
      OP_SUB:    r = b - a;
      OP_MUL:    r = prod;
      default:   r = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/core/smeu_div.sv @@
`default_nettype none
module smeu_div
  import smeu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic [31:0]      quotient
);

  logic        run;
  logic        neg;
  logic [4:0]  cnt;
  logic [31:0] rem;
  logic [31:0] num;
  logic [31:0] dv;
  logic [32:0] sh;
  logic [32:0] trial;

  assign sh       = {rem, num[31]};
  assign trial    = sh - {1'b0, dv};
  assign quotient = neg ? -num : num;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Restoring division on magnitudes, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[31] ^ divisor[31];
      num <= dividend[31] ? -dividend : dividend;
      dv  <= divisor[31] ? -divisor : divisor;
      rem <= '0;
    end else if (run) begin
      if (!trial[32]) begin
        rem <= trial[31:0];
        num <= {num[30:0], 1'b1};
      end else begin
        rem <= sh[31:0];
        num <= {num[30:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/stack_machine_execute_unit.sv @@
`default_nettype none
// A word is accepted in S_IDLE, its operands are read in S_RA to S_RD, it is executed
// in S_EX (divide then waits in S_DIV for the iterative divider), and the stack entries
// it writes (up to three, for rot) are written one at a time in S_WR. One word is
// processed at a time: no new word is accepted until the last one has left S_WR.
// Reset is synchronous; afterwards a clearing pass zeroes every word of the word
// memory, during which no word is accepted.
module stack_machine_execute_unit
  import smeu_pkg::*;
#(
  parameter int STACK_DEPTH  = 128,
  parameter int MEMORY_WORDS = 1024
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_valid,
  output logic      cmd_ready,
  input  wire in_t  cmd,
  output logic      rsp_valid,
  input  wire logic rsp_ready,
  output out_t      rsp
);

  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int DW  = $clog2(STACK_DEPTH + 1);
  localparam int AW  = $clog2(MEMORY_WORDS);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_RA   = 4'd2;
  localparam logic [3:0] S_RB   = 4'd3;
  localparam logic [3:0] S_RC   = 4'd4;
  localparam logic [3:0] S_RD   = 4'd5;
  localparam logic [3:0] S_EX   = 4'd6;
  localparam logic [3:0] S_DIV  = 4'd7;
  localparam logic [3:0] S_WR   = 4'd8;

  logic [3:0]      state;
  logic [DW-1:0]   depth;
  logic [AW-1:0]   clr_cnt;
  logic [4:0]      mode;
  logic [31:0]     lit;
  logic [31:0]     a;
  logic [31:0]     b;
  logic [31:0]     c;

  logic [31:0]     stk [STACK_DEPTH];
  logic [31:0]     wmem [MEMORY_WORDS];
  logic [SAW-1:0]  sraddr;
  logic [31:0]     srd;
  logic [31:0]     wrd;

  logic [SAW-1:0]  waddr [3];
  logic [31:0]     wdata [3];
  logic [1:0]      wcnt;
  logic [1:0]      wi;
  out_t            res;
  logic [DW-1:0]   nd_q;

  logic [SAW-1:0]  d0, dm1, dm2, dm3;
  logic [31:0]     alu_r;
  logic [31:0]     rr;
  logic            div_start;
  logic            div_done;
  logic [31:0]     div_q;
  logic            addr_ok;
  logic            grows;
  logic [2:0]      err;
  logic            go;
  logic            rsp_load;

  logic [DW-1:0]   p_nd;
  logic [31:0]     p_top;
  logic [1:0]      p_cnt;
  logic [SAW-1:0]  p_addr [3];
  logic [31:0]     p_data [3];
  logic [1:0]      p_kind;
  logic [31:0]     p_pval;
  logic            p_mwe;

  smeu_alu u_alu (
    .mode (mode),
    .a    (a),
    .b    (b),
    .r    (alu_r)
  );

  smeu_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (b),
    .divisor  (a),
    .done     (div_done),
    .quotient (div_q)
  );

  assign cmd_ready = (state == S_IDLE);
  assign d0  = SAW'(depth);
  assign dm1 = SAW'(depth - DW'(1));
  assign dm2 = SAW'(depth - DW'(2));
  assign dm3 = SAW'(depth - DW'(3));
  assign rr  = (state == S_DIV) ? div_q : alu_r;

  assign addr_ok = !a[31] && (a < 32'(MEMORY_WORDS));
  assign grows   = (mode == OP_PUSH) || (mode == OP_DUP) || (mode == OP_OVER);

  always_comb begin
    if (mode > OP_STORE)                                err = ERR_NONE;
    else if (depth < DW'(need_f(mode)))                 err = ERR_UNDER;
    else if (grows && depth >= DW'(STACK_DEPTH))        err = ERR_OVER;
    else if (mode == OP_DIV && a == 32'd0)              err = ERR_DIVZ;
    else if ((mode == OP_FETCH || mode == OP_STORE) && !addr_ok) err = ERR_ADDR;
    else                                                err = ERR_NONE;
  end

  assign div_start = (state == S_EX) && (mode == OP_DIV) && (err == ERR_NONE);
  assign go = ((state == S_EX) && !div_start) || ((state == S_DIV) && div_done);
  assign rsp_load = (state == S_WR) && (wi == wcnt) && (!rsp_valid || rsp_ready);

  // Stack writes, new depth, new top, print output and word-memory write for the operation in hand.
  always_comb begin
    p_nd   = depth;
    p_top  = a;
    p_cnt  = 2'd0;
    p_kind = PK_NONE;
    p_pval = 32'd0;
    p_mwe  = 1'b0;
    for (int i = 0; i < 3; i++) begin
      p_addr[i] = dm1;
      p_data[i] = rr;
    end
    if (err == ERR_NONE) begin
      case (mode)
        OP_PUSH: begin
          p_addr[0] = d0; p_data[0] = lit; p_cnt = 2'd1;
          p_nd = depth + DW'(1); p_top = lit;
        end
        OP_DUP: begin
          p_addr[0] = d0; p_data[0] = a; p_cnt = 2'd1;
          p_nd = depth + DW'(1);
        end
        OP_OVER: begin
          p_addr[0] = d0; p_data[0] = b; p_cnt = 2'd1;
          p_nd = depth + DW'(1); p_top = b;
        end
        OP_DROP: begin
          p_nd = depth - DW'(1); p_top = b;
        end
        OP_SWAP: begin
          p_addr[0] = dm1; p_data[0] = b;
          p_addr[1] = dm2; p_data[1] = a;
          p_cnt = 2'd2; p_top = b;
        end
        OP_ROT: begin
          p_addr[0] = dm3; p_data[0] = b;
          p_addr[1] = dm2; p_data[1] = a;
          p_addr[2] = dm1; p_data[2] = c;
          p_cnt = 2'd3; p_top = c;
        end
        OP_DOT: begin
          p_kind = PK_NUM; p_pval = a;
          p_nd = depth - DW'(1); p_top = b;
        end
        OP_EMIT: begin
          p_kind = PK_CHAR; p_pval = {24'd0, a[7:0]};
          p_nd = depth - DW'(1); p_top = b;
        end
        OP_CR: begin
          p_kind = PK_NL;
        end
        OP_INVERT: begin
          p_addr[0] = dm1; p_data[0] = alu_r; p_cnt = 2'd1; p_top = alu_r;
        end
        OP_FETCH: begin
          p_addr[0] = dm1; p_data[0] = wrd; p_cnt = 2'd1; p_top = wrd;
        end
        OP_STORE: begin
          p_mwe = 1'b1; p_nd = depth - DW'(2); p_top = c;
        end
        OP_EQ, OP_LT, OP_GT, OP_AND, OP_OR,
        OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
          p_addr[0] = dm2; p_data[0] = rr; p_cnt = 2'd1;
          p_nd = depth - DW'(1); p_top = rr;
        end
        default: begin
          p_cnt = 2'd0;
        end
      endcase
    end
    if (p_nd == '0) p_top = 32'd0;
  end

  always_comb begin
    case (state)
      S_RA:    sraddr = dm1;
      S_RB:    sraddr = dm2;
      default: sraddr = dm3;
    endcase
  end

  always_ff @(posedge clk) begin
    srd <= stk[sraddr];
    wrd <= wmem[a[AW-1:0]];
    if (state == S_WR && wi < wcnt) stk[waddr[wi]] <= wdata[wi];
    if (state == S_CLR) begin
      wmem[clr_cnt] <= 32'd0;
    end else if (go && p_mwe) begin
      wmem[a[AW-1:0]] <= b;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      mode <= cmd.mode;
      lit  <= cmd.literal;
    end
    if (state == S_RB) a <= srd;
    if (state == S_RC) b <= srd;
    if (state == S_RD) c <= srd;
    if (go) begin
      for (int i = 0; i < 3; i++) begin
        waddr[i] <= p_addr[i];
        wdata[i] <= p_data[i];
      end
      wcnt            <= p_cnt;
      nd_q            <= p_nd;
      res.print_kind  <= p_kind;
      res.print_value <= p_pval;
      res.error_code  <= err;
      res.depth_after <= 8'(p_nd);
      res.top_after   <= p_top;
    end
    if (rsp_load) rsp <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_cnt   <= '0;
      depth     <= '0;
      wi        <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_load) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
      case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == AW'(MEMORY_WORDS - 1)) state <= S_IDLE;
        end
        S_IDLE: if (cmd_valid) state <= S_RA;
        S_RA:   state <= S_RB;
        S_RB:   state <= S_RC;
        S_RC:   state <= S_RD;
        S_RD:   state <= S_EX;
        S_EX: begin
          wi <= '0;
          state <= div_start ? S_DIV : S_WR;
        end
        S_DIV:  if (div_done) state <= S_WR;
        S_WR: begin
          if (wi < wcnt) begin
            wi <= wi + 2'd1;
          end else if (!rsp_valid || rsp_ready) begin
            // The result word leaves only after all stack writes are done.
            depth     <= nd_q;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= DW'(STACK_DEPTH)) else $error("stack depth above capacity");

  a_err_silent: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.error_code != ERR_NONE |-> rsp.print_kind == PK_NONE
      && rsp.print_value == 32'd0) else $error("print on error");

  a_err_keeps_depth: assert property (@(posedge clk) disable iff (rst)
    go && err != ERR_NONE |-> p_nd == depth && p_cnt == 2'd0 && !p_mwe)
    else $error("state change on error");

  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    state == S_CLR |-> !cmd_ready) else $error("accept during clear");
`endif

endmodule
`default_nettype wire
